// ===== sv/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

   // default sizes
   localparam int NUM_BLOCKS_DEF      = 512;
   localparam int MAX_FILES_DEF       = 512;
   localparam int BLOCKS_PER_FILE_DEF = 5;

   // payload widths
   localparam int TYPE_W   = 2;
   localparam int KEY_W    = 16;
   localparam int SIZE_W   = 10;
   localparam int STATUS_W = 3;
   localparam int BLKNUM_W = 9;
   localparam int NEED_W   = 6;

   // one block is 2.0 KB, i.e. 20 tenths; ceil(size/20) = ((size + 19) * 3277) >> 16
   localparam int                 SUM_W     = 11;
   localparam int                 PROD_W    = 23;
   localparam logic [SUM_W-1:0]   SIZE_BIAS = 11'd19;
   localparam logic [PROD_W-1:0]  RECIP20   = 23'd3277;
   localparam int                 RECIP_SH  = 16;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NOROOM   = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_TOOLARGE = 3'd4
   } status_type;

   typedef enum logic [TYPE_W-1:0] {
      REQ_CREATE = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   // controller to datapath
   typedef struct packed {
      logic       req_ready;
      logic       clr_step;
      logic       bidx_zero;
      logic       bm_rd;
      logic       bidx_inc;
      logic       take;
      logic       tb_new;
      logic       fidx_zero;
      logic       fidx_inc;
      logic       tb_rd;
      logic       j_zero;
      logic       q_emit;
      logic       r_free;
      logic       c_rd;
      logic       c_wr;
      logic       total_dec;
      logic       emit;
      status_type code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic is_create;
      logic is_remove;
      logic is_query;
      logic too_large;
      logic full;
      logic no_room;
      logic need_zero;
      logic bm_used;
      logic scan_last;
      logic tb_match;
      logic tb_last;
      logic total_zero;
      logic q_zero;
      logic q_last;
      logic j_end;
      logic more_move;
      logic move_more;
      logic out_free;
      logic clear_last;
   } sts_type;

endpackage

`default_nettype wire

// ===== sv/bba_ifs.sv =====
`default_nettype none

interface bba_req_if;
   logic                             valid;
   logic                             ready;
   logic [bba_pkg::TYPE_W-1:0]       req_type;
   logic [bba_pkg::KEY_W-1:0]        file_key;
   logic [bba_pkg::SIZE_W-1:0]       size_tenths_kb;
   modport source (output valid, req_type, file_key, size_tenths_kb, input ready);
   modport sink   (input valid, req_type, file_key, size_tenths_kb, output ready);
endinterface

interface bba_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bba_pkg::STATUS_W-1:0]     status;
   logic                             block_valid;
   logic [bba_pkg::BLKNUM_W-1:0]     block_number;
   logic                             last;
   modport source (output valid, status, block_valid, block_number, last, input ready);
   modport sink   (input valid, status, block_valid, block_number, last, output ready);
endinterface

`default_nettype wire

// ===== sv/bitmap_block_allocator_file_table.sv =====
`default_nettype none

// channel   dir  handshake     payload
// req_chan  in   valid/ready   req_type, file_key, size_tenths_kb
// rsp_chan  out  valid/ready   status, block_valid, block_number, last
//
// One request at a time. Create scans the bitmap, reading and checking each
// block in turn, until its blocks are found; remove and query search the
// table entry by entry, and remove then frees one block a cycle and compacts
// the table, reading and writing back each moved entry.
// After reset a clearing pass runs over every bitmap block before the first
// request is accepted. A stalled result holds the sequencer.
module bitmap_block_allocator_file_table #(
   parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_FILES       = bba_pkg::MAX_FILES_DEF,
   parameter int BLOCKS_PER_FILE = bba_pkg::BLOCKS_PER_FILE_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bba_req_if.sink    req_chan,
   bba_rsp_if.source  rsp_chan
);

   bba_pkg::cmd_type  cmd;
   bba_pkg::sts_type  sts;

   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   bba_dp #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .MAX_FILES       (MAX_FILES),
      .BLOCKS_PER_FILE (BLOCKS_PER_FILE)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

   // a result is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.take || cmd.q_emit || cmd.emit) |-> sts.out_free)
      else $error("result loaded over a pending item");

   // only free blocks are taken
   a_take_free: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !sts.bm_used)
      else $error("used block taken");

   // one request in flight
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request accepted while busy");

endmodule

`default_nettype wire

// ===== sv/bba_ctrl.sv =====
`default_nettype none

module bba_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  bba_pkg::sts_type  sts,
   output bba_pkg::cmd_type  cmd
);

   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_DECODE = 14'b00000000000100,
      S_BM_RD  = 14'b00000000001000,
      S_BM_CHK = 14'b00000000010000,
      S_TB_NEW = 14'b00000000100000,
      S_TB_RD  = 14'b00000001000000,
      S_TB_CHK = 14'b00000010000000,
      S_Q_OUT  = 14'b00000100000000,
      S_R_FREE = 14'b00001000000000,
      S_C_RD   = 14'b00010000000000,
      S_C_WR   = 14'b00100000000000,
      S_R_DONE = 14'b01000000000000,
      S_EMIT   = 14'b10000000000000
   } state_type;

   state_type            state_ff, state_in;
   bba_pkg::status_type  code_ff, code_in;

   // hold state and pending status code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= bba_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // sequence one item at a time
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.bidx_zero = 1'b1;
            cmd.fidx_zero = 1'b1;
            cmd.j_zero    = 1'b1;
            if (sts.is_create) begin
               if (sts.too_large) begin
                  code_in  = bba_pkg::ST_TOOLARGE;
                  state_in = S_EMIT;
               end else if (sts.full) begin
                  code_in  = bba_pkg::ST_FULL;
                  state_in = S_EMIT;
               end else if (sts.no_room) begin
                  code_in  = bba_pkg::ST_NOROOM;
                  state_in = S_EMIT;
               end else if (sts.need_zero) begin
                  code_in  = bba_pkg::ST_OK;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_BM_RD;
               end
            end else if (sts.is_remove || sts.is_query) begin
               if (sts.total_zero) begin
                  code_in  = bba_pkg::ST_NOTFOUND;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_TB_RD;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_BM_RD: begin
            cmd.bm_rd = 1'b1;
            state_in  = S_BM_CHK;
         end
         S_BM_CHK: begin
            if (sts.bm_used) begin
               cmd.bidx_inc = 1'b1;
               state_in     = S_BM_RD;
            end else if (sts.out_free) begin
               cmd.take     = 1'b1;
               cmd.bidx_inc = 1'b1;
               state_in     = sts.scan_last ? S_TB_NEW : S_BM_RD;
            end
         end
         S_TB_NEW: begin
            cmd.tb_new = 1'b1;
            state_in   = S_IDLE;
         end
         S_TB_RD: begin
            cmd.tb_rd = 1'b1;
            state_in  = S_TB_CHK;
         end
         S_TB_CHK: begin
            if (sts.tb_match) begin
               if (sts.is_remove) begin
                  state_in = S_R_FREE;
               end else if (sts.q_zero) begin
                  code_in  = bba_pkg::ST_OK;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_Q_OUT;
               end
            end else if (sts.tb_last) begin
               code_in  = bba_pkg::ST_NOTFOUND;
               state_in = S_EMIT;
            end else begin
               cmd.fidx_inc = 1'b1;
               state_in     = S_TB_RD;
            end
         end
         S_Q_OUT: begin
            if (sts.out_free) begin
               cmd.q_emit = 1'b1;
               if (sts.q_last) state_in = S_IDLE;
            end
         end
         S_R_FREE: begin
            if (!sts.j_end) begin
               cmd.r_free = 1'b1;
            end else begin
               state_in = sts.more_move ? S_C_RD : S_R_DONE;
            end
         end
         S_C_RD: begin
            cmd.c_rd = 1'b1;
            state_in = S_C_WR;
         end
         S_C_WR: begin
            cmd.c_wr     = 1'b1;
            cmd.fidx_inc = 1'b1;
            state_in     = sts.move_more ? S_C_RD : S_R_DONE;
         end
         S_R_DONE: begin
            cmd.total_dec = 1'b1;
            code_in       = bba_pkg::ST_OK;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = (sts.is_create && code_ff == bba_pkg::ST_OK) ? S_TB_NEW : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/bba_dp.sv =====
`default_nettype none

module bba_dp #(
   parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_FILES       = bba_pkg::MAX_FILES_DEF,
   parameter int BLOCKS_PER_FILE = bba_pkg::BLOCKS_PER_FILE_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   bba_req_if.sink           req_chan,
   bba_rsp_if.source         rsp_chan,
   input  bba_pkg::cmd_type  cmd,
   output bba_pkg::sts_type  sts
);

   localparam int BW  = $clog2(NUM_BLOCKS);
   localparam int FW  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int TW  = $clog2(MAX_FILES + 1);
   localparam int TW1 = TW + 1;
   localparam int CW  = $clog2(NUM_BLOCKS + 1);
   localparam int JW  = $clog2(BLOCKS_PER_FILE + 1);
   localparam int JI  = (BLOCKS_PER_FILE > 1) ? $clog2(BLOCKS_PER_FILE) : 1;
   localparam int LW  = BLOCKS_PER_FILE * BW;
   localparam int EW  = bba_pkg::KEY_W + JW + LW;
   localparam int NW  = bba_pkg::NEED_W + 1;
   localparam int FCW = 14;

   // request registers
   logic [bba_pkg::TYPE_W-1:0]           type_ff;
   logic [bba_pkg::KEY_W-1:0]            key_ff;
   logic [bba_pkg::NEED_W-1:0]           need_ff;
   logic [bba_pkg::PROD_W-1:0]           need_prod;
   // counters and indexes
   logic [BW-1:0]                        bidx_ff;
   logic [FW-1:0]                        fidx_ff;
   logic [TW-1:0]                        total_ff;
   logic [CW-1:0]                        free_ff;
   logic [JW-1:0]                        j_ff;
   logic [BLOCKS_PER_FILE-1:0][BW-1:0]   buf_ff;
   // memories
   logic                                 bm_mem [NUM_BLOCKS];
   logic                                 bm_rd_ff;
   logic [EW-1:0]                        tbl_mem [MAX_FILES];
   logic [EW-1:0]                        tbl_rd_ff;
   // read entry fields
   logic [bba_pkg::KEY_W-1:0]            rd_key;
   logic [JW-1:0]                        rd_cnt;
   logic [BLOCKS_PER_FILE-1:0][BW-1:0]   rd_blk;
   logic [BW-1:0]                        rd_cur;
   logic [TW1-1:0]                       fidx_p1;
   logic [TW1-1:0]                       fidx_p2;
   // bitmap write port
   logic                                 bm_we;
   logic [BW-1:0]                        bm_wa;
   logic                                 bm_wd;
   // table ports
   logic                                 tb_we;
   logic [FW-1:0]                        tb_wa;
   logic [EW-1:0]                        tb_wd;
   logic                                 tb_re;
   logic [FW-1:0]                        tb_ra;
   // result register
   logic                                 rsp_valid_ff;
   logic [bba_pkg::STATUS_W-1:0]         rsp_status_ff;
   logic                                 rsp_bvalid_ff;
   logic [bba_pkg::BLKNUM_W-1:0]         rsp_blk_ff;
   logic                                 rsp_last_ff;
   logic                                 out_free;
   logic                                 req_fire;

   assign req_chan.ready = cmd.req_ready;
   assign req_fire       = req_chan.valid && cmd.req_ready;

   // ceil(size / 20) by reciprocal multiply
   assign need_prod = bba_pkg::PROD_W'(bba_pkg::SUM_W'(req_chan.size_tenths_kb)
                      + bba_pkg::SIZE_BIAS) * bba_pkg::RECIP20;

   assign rd_key  = tbl_rd_ff[EW-1 -: bba_pkg::KEY_W];
   assign rd_cnt  = tbl_rd_ff[LW +: JW];
   assign rd_blk  = tbl_rd_ff[LW-1:0];
   assign rd_cur  = rd_blk[j_ff[JI-1:0]];
   assign fidx_p1 = TW1'(fidx_ff) + TW1'(1);
   assign fidx_p2 = TW1'(fidx_ff) + TW1'(2);

   // latch request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff <= req_chan.req_type;
         key_ff  <= req_chan.file_key;
         need_ff <= need_prod[bba_pkg::RECIP_SH +: bba_pkg::NEED_W];
      end
   end

   // advance counters
   always_ff @(posedge clock) begin
      if (reset) begin
         bidx_ff  <= '0;
         fidx_ff  <= '0;
         total_ff <= '0;
         free_ff  <= CW'(NUM_BLOCKS);
         j_ff     <= '0;
      end else begin
         if (cmd.bidx_zero) bidx_ff <= '0;
         else if (cmd.clr_step || cmd.bidx_inc) bidx_ff <= bidx_ff + BW'(1);
         if (cmd.fidx_zero) fidx_ff <= '0;
         else if (cmd.fidx_inc) fidx_ff <= fidx_ff + FW'(1);
         if (cmd.tb_new) total_ff <= total_ff + TW'(1);
         else if (cmd.total_dec) total_ff <= total_ff - TW'(1);
         if (cmd.take) free_ff <= free_ff - CW'(1);
         else if (cmd.r_free) free_ff <= free_ff + CW'(1);
         if (cmd.j_zero) j_ff <= '0;
         else if (cmd.take || cmd.q_emit || cmd.r_free) j_ff <= j_ff + JW'(1);
      end
   end

   // collect allocated blocks
   always_ff @(posedge clock) begin
      if (cmd.take) buf_ff[j_ff[JI-1:0]] <= bidx_ff;
   end

   // bitmap port select
   always_comb begin
      bm_we = cmd.clr_step || cmd.take || cmd.r_free;
      bm_wa = cmd.r_free ? rd_cur : bidx_ff;
      bm_wd = cmd.take;
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_wa] <= bm_wd;
      if (cmd.bm_rd) bm_rd_ff <= bm_mem[bidx_ff];
   end

   // table port select
   always_comb begin
      tb_we = cmd.tb_new || cmd.c_wr;
      tb_wa = cmd.tb_new ? FW'(total_ff) : fidx_ff;
      tb_wd = cmd.tb_new ? {key_ff, JW'(need_ff), buf_ff} : tbl_rd_ff;
      tb_re = cmd.tb_rd || cmd.c_rd;
      tb_ra = cmd.c_rd ? FW'(fidx_p1) : fidx_ff;
   end

   always_ff @(posedge clock) begin
      if (tb_we) tbl_mem[tb_wa] <= tb_wd;
      if (tb_re) tbl_rd_ff <= tbl_mem[tb_ra];
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.take || cmd.q_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.code;
         rsp_bvalid_ff <= 1'b0;
         rsp_blk_ff    <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.take) begin
         rsp_status_ff <= bba_pkg::ST_OK;
         rsp_bvalid_ff <= 1'b1;
         rsp_blk_ff    <= bba_pkg::BLKNUM_W'(bidx_ff);
         rsp_last_ff   <= sts.scan_last;
      end else if (cmd.q_emit) begin
         rsp_status_ff <= bba_pkg::ST_OK;
         rsp_bvalid_ff <= 1'b1;
         rsp_blk_ff    <= bba_pkg::BLKNUM_W'(rd_cur);
         rsp_last_ff   <= sts.q_last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.block_valid  = rsp_bvalid_ff;
   assign rsp_chan.block_number = rsp_blk_ff;
   assign rsp_chan.last         = rsp_last_ff;

   // status to controller
   always_comb begin
      sts.req_valid  = req_chan.valid;
      sts.is_create  = type_ff == bba_pkg::REQ_CREATE;
      sts.is_remove  = type_ff == bba_pkg::REQ_REMOVE;
      sts.is_query   = type_ff == bba_pkg::REQ_QUERY;
      sts.too_large  = NW'(need_ff) > NW'(BLOCKS_PER_FILE);
      sts.full       = total_ff == TW'(MAX_FILES);
      sts.no_room    = FCW'(free_ff) < FCW'(need_ff);
      sts.need_zero  = need_ff == '0;
      sts.bm_used    = bm_rd_ff;
      sts.scan_last  = NW'(j_ff) + NW'(1) == NW'(need_ff);
      sts.tb_match   = rd_key == key_ff;
      sts.tb_last    = fidx_p1 == TW1'(total_ff);
      sts.total_zero = total_ff == '0;
      sts.q_zero     = rd_cnt == '0;
      sts.q_last     = NW'(j_ff) + NW'(1) == NW'(rd_cnt);
      sts.j_end      = j_ff == rd_cnt;
      sts.more_move  = fidx_p1 < TW1'(total_ff);
      sts.move_more  = fidx_p2 < TW1'(total_ff);
      sts.out_free   = out_free;
      sts.clear_last = bidx_ff == BW'(NUM_BLOCKS - 1);
   end

endmodule

`default_nettype wire
